>>> sv/xxtea_pkg.sv
package xxtea_pkg;

	localparam int WORD_W      = 32;
	localparam int BLOCK_WORDS = 9;
	localparam int ROUND_COUNT = 11;
	localparam int IO_WORDS    = 9;
	localparam int KEY_WORDS   = 4;
	localparam int PREP_STEPS  = 4;

	localparam int IDX_W = $clog2(BLOCK_WORDS);
	localparam int RND_W = $clog2(ROUND_COUNT + 1);
	localparam int CNT_W = $clog2(ROUND_COUNT / 4 + 2);
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_0   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_3 = 4'd7;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  mode;
		word_t in_word_0;
		word_t in_word_1;
		word_t in_word_2;
		word_t in_word_3;
		word_t in_word_4;
		word_t in_word_5;
		word_t in_word_6;
		word_t in_word_7;
		word_t in_word_8;
	} in_item_t;

	typedef struct packed {
		word_t out_word_0;
		word_t out_word_1;
		word_t out_word_2;
		word_t out_word_3;
		word_t out_word_4;
		word_t out_word_5;
		word_t out_word_6;
		word_t out_word_7;
		word_t out_word_8;
	} out_item_t;

	typedef struct packed {
		word_t [KEY_WORDS-1:0] key;
		word_t [KEY_WORDS-1:0] delta;
	} cfg_regs_t;

	typedef struct packed {
		logic load;
		logic step;
		logic dec;
	} ring_ctl_t;

	// Weight of delta word m in the starting sum: the number of rounds that
	// use it when decrypting, or only the first round's delta when encrypting.
	function automatic logic [CNT_W-1:0] prep_factor(logic dec, logic [1:0] m);
		int cnt;
		cnt = 0;
		if (dec) begin
			if (m == 2'd0)
				cnt = ROUND_COUNT >> 2;
			else
				cnt = (ROUND_COUNT + 4 - int'(m)) >> 2;
		end else begin
			cnt = (int'(m) == (ROUND_COUNT % 4)) ? 1 : 0;
		end
		return CNT_W'(cnt);
	endfunction

endpackage

>>> sv/xxtea_cfg.sv
module xxtea_cfg import xxtea_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				[REG_KEY_0:REG_KEY_3]:     regs_q.key[cfg_index[1:0]] <= cfg_data;
				[REG_DELTA_0:REG_DELTA_3]: regs_q.delta[cfg_index[1:0]] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> sv/xxtea_mix.sv
module xxtea_mix import xxtea_pkg::*; (
	input  word_t x,
	input  word_t y,
	input  word_t z,
	input  word_t sum,
	input  word_t key,
	input  logic  dec,
	output word_t result
);

	word_t a;
	word_t b;
	word_t m;

	always_comb begin
		a = ((z << 4) ^ (y >> 3)) + ((y << 2) ^ (z >> 5));
		b = (y ^ sum) + (z ^ key);
		m = a ^ b;
		result = dec ? (x - m) : (x + m);
	end

endmodule

>>> sv/xxtea_ring.sv
module xxtea_ring import xxtea_pkg::*; (
	input  logic                     clk,
	input  ring_ctl_t                ctl,
	input  word_t [BLOCK_WORDS-1:0]  ld_words,
	input  word_t                    new_word,
	output word_t                    cur,
	output word_t                    nxt,
	output word_t                    prv,
	output word_t [BLOCK_WORDS-1:0]  words
);

	// Slot 0 holds the word being updated, slot 1 its successor and the last
	// slot its predecessor. Decryption runs with the ring offset by one.
	word_t [BLOCK_WORDS-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int k = 0; k < BLOCK_WORDS; k++) begin
				slot_q[k] <= ctl.dec ? ld_words[(k + BLOCK_WORDS - 1) % BLOCK_WORDS]
				                     : ld_words[k];
			end
		end else if (ctl.step) begin
			if (ctl.dec) begin
				slot_q[0] <= slot_q[BLOCK_WORDS-1];
				slot_q[1] <= new_word;
				for (int k = 2; k < BLOCK_WORDS; k++)
					slot_q[k] <= slot_q[k-1];
			end else begin
				for (int k = 0; k < BLOCK_WORDS - 1; k++)
					slot_q[k] <= slot_q[k+1];
				slot_q[BLOCK_WORDS-1] <= new_word;
			end
		end
	end

	assign cur = slot_q[0];
	assign nxt = slot_q[1];
	assign prv = slot_q[BLOCK_WORDS-1];

	for (genvar j = 0; j < BLOCK_WORDS; j++) begin : g_words
		assign words[j] = ctl.dec ? slot_q[(j + 1) % BLOCK_WORDS] : slot_q[j];
	end

endmodule

>>> sv/xxtea_nine_word_cipher_unit.sv
// Flow: after the input transfer the unit forms the starting round sum, runs
// the word updates and registers the result, which then shows valid.
// Throughput: the unit takes no new block until the last result is loaded;
// the single mix adder does one word update per cycle, 9 words times 11 rounds.
// Reset: key and delta registers clear to zero, sequencer idle, no result held.
module xxtea_nine_word_cipher_unit import xxtea_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  in_item_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output out_item_t            rsp
);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN, S_DONE} state_t;

	state_t           state_q;
	logic             mode_q;
	logic [1:0]       prep_q;
	logic [IDX_W-1:0] idx_q;
	logic [RND_W-1:0] rnd_q;
	word_t            sum_q;
	logic             rsp_valid_q;
	out_item_t        rsp_q;

	cfg_regs_t regs;
	ring_ctl_t ring_ctl;
	logic      req_xfer;
	logic      last_word;
	logic      last_round;
	logic      rsp_load;

	word_t [IO_WORDS-1:0]    req_words;
	word_t [IO_WORDS-1:0]    rsp_words;
	word_t [BLOCK_WORDS-1:0] ld_words;
	word_t [BLOCK_WORDS-1:0] ring_words;
	word_t                   cur;
	word_t                   nxt;
	word_t                   prv;
	word_t                   new_word;
	word_t                   key_sel;
	word_t                   delta_sel;
	logic [RND_W-1:0]        rnd_dec;
	logic [WORD_W+CNT_W-1:0] prep_term;

	xxtea_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	assign req_words[0] = req.in_word_0;
	assign req_words[1] = req.in_word_1;
	assign req_words[2] = req.in_word_2;
	assign req_words[3] = req.in_word_3;
	assign req_words[4] = req.in_word_4;
	assign req_words[5] = req.in_word_5;
	assign req_words[6] = req.in_word_6;
	assign req_words[7] = req.in_word_7;
	assign req_words[8] = req.in_word_8;

	for (genvar j = 0; j < BLOCK_WORDS; j++) begin : g_load
		if (j < IO_WORDS) begin : g_in
			assign ld_words[j] = req_words[j];
		end else begin : g_zero
			assign ld_words[j] = '0;
		end
	end

	// Words past the cipher span pass through untouched.
	for (genvar j = 0; j < IO_WORDS; j++) begin : g_out
		if (j < BLOCK_WORDS) begin : g_ring
			assign rsp_words[j] = ring_words[j];
		end else begin : g_pass
			word_t pass_q;
			always_ff @(posedge clk) begin
				if (req_xfer)
					pass_q <= req_words[j];
			end
			assign rsp_words[j] = pass_q;
		end
	end

	assign req_xfer  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		ring_ctl.load = req_xfer;
		ring_ctl.step = (state_q == S_RUN);
		ring_ctl.dec  = req_xfer ? req.mode : mode_q;
	end

	xxtea_ring u_ring (
		.clk      (clk),
		.ctl      (ring_ctl),
		.ld_words (ld_words),
		.new_word (new_word),
		.cur      (cur),
		.nxt      (nxt),
		.prv      (prv),
		.words    (ring_words)
	);

	assign key_sel = regs.key[2'(idx_q) ^ sum_q[3:2]];

	xxtea_mix u_mix (
		.x      (cur),
		.y      (nxt),
		.z      (prv),
		.sum    (sum_q),
		.key    (key_sel),
		.dec    (mode_q),
		.result (new_word)
	);

	always_comb begin
		rnd_dec    = rnd_q - RND_W'(1);
		delta_sel  = mode_q ? regs.delta[2'(rnd_q)] : regs.delta[2'(rnd_dec)];
		prep_term  = regs.delta[prep_q] * prep_factor(mode_q, prep_q);
		last_word  = mode_q ? (idx_q == '0) : (idx_q == IDX_W'(BLOCK_WORDS - 1));
		last_round = mode_q ? (rnd_q == RND_W'(ROUND_COUNT)) : (rnd_q == RND_W'(1));
		rsp_load   = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			prep_q      <= '0;
			idx_q       <= '0;
			rnd_q       <= '0;
			sum_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						mode_q  <= req.mode;
						prep_q  <= '0;
						sum_q   <= '0;
						idx_q   <= req.mode ? IDX_W'(BLOCK_WORDS - 1) : '0;
						rnd_q   <= req.mode ? RND_W'(1) : RND_W'(ROUND_COUNT);
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					sum_q  <= sum_q + prep_term[WORD_W-1:0];
					prep_q <= prep_q + 2'd1;
					if (prep_q == 2'(PREP_STEPS - 1))
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (last_word) begin
						idx_q <= mode_q ? IDX_W'(BLOCK_WORDS - 1) : '0;
						if (last_round) begin
							state_q <= S_DONE;
						end else if (mode_q) begin
							sum_q <= sum_q - delta_sel;
							rnd_q <= rnd_q + RND_W'(1);
						end else begin
							sum_q <= sum_q + delta_sel;
							rnd_q <= rnd_dec;
						end
					end else begin
						idx_q <= mode_q ? (idx_q - IDX_W'(1)) : (idx_q + IDX_W'(1));
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (rsp_load) begin
						rsp_q.out_word_0 <= rsp_words[0];
						rsp_q.out_word_1 <= rsp_words[1];
						rsp_q.out_word_2 <= rsp_words[2];
						rsp_q.out_word_3 <= rsp_words[3];
						rsp_q.out_word_4 <= rsp_words[4];
						rsp_q.out_word_5 <= rsp_words[5];
						rsp_q.out_word_6 <= rsp_words[6];
						rsp_q.out_word_7 <= rsp_words[7];
						rsp_q.out_word_8 <= rsp_words[8];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing state");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> req_stall && (state_q == S_PREP))
		else $error("block took a transfer without starting work");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (idx_q <= IDX_W'(BLOCK_WORDS - 1)))
		else $error("word index out of range");

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (rnd_q != '0) && (rnd_q <= RND_W'(ROUND_COUNT)))
		else $error("round counter out of range");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import xxtea_pkg::*;;

	typedef word_t [0:IO_WORDS-1] blk_t;

	class block_scoreboard;
		word_t key_reg[KEY_WORDS];
		word_t delta_reg[4];
		out_item_t expected_blocks[$];
		int errors;

		function new();
			foreach (key_reg[i]) key_reg[i] = '0;
			foreach (delta_reg[i]) delta_reg[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
			if (idx <= REG_KEY_3)
				key_reg[idx[1:0]] = value;
			else if (idx >= REG_DELTA_0 && idx <= REG_DELTA_3)
				delta_reg[idx[1:0]] = value;
			// anything above the delta words is dropped
		endfunction

		function word_t mix(word_t y, word_t z, word_t sum, int idx);
			word_t k, a, b;
			k = key_reg[sum[3:2] ^ idx[1:0]];
			a = ((z << 4) ^ (y >> 3)) + ((y << 2) ^ (z >> 5));
			b = (y ^ sum) + (z ^ k);
			return a ^ b;
		endfunction

		function out_item_t cipher_block(in_item_t it);
			blk_t v;
			word_t sum;
			int n;
			v = it[IO_WORDS*WORD_W-1:0];
			n = BLOCK_WORDS;
			sum = '0;
			if (!it.mode) begin
				for (int r = ROUND_COUNT; r > 0; r--) begin
					sum += delta_reg[r % 4];
					for (int i = 0; i < n; i++)
						v[i] += mix(v[(i + 1) % n], v[(i + n - 1) % n], sum, i);
				end
			end else begin
				// start from the last encryption sum and walk the sums back
				for (int r = ROUND_COUNT; r > 0; r--)
					sum += delta_reg[r % 4];
				for (int r = 1; r <= ROUND_COUNT; r++) begin
					for (int p = n - 1; p >= 0; p--)
						v[p] -= mix(v[(p + 1) % n], v[(p + n - 1) % n], sum, p);
					sum -= delta_reg[r % 4];
				end
			end
			return out_item_t'(v);
		endfunction

		function void note_block(in_item_t it);
			expected_blocks.push_back(cipher_block(it));
		endfunction

		function void check_block(out_item_t got);
			out_item_t want;
			blk_t w, g;
			if (expected_blocks.size() == 0) begin
				errors++;
				$display("%0t: result with no block pending, expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_blocks.pop_front();
			w = want;
			g = got;
			for (int i = 0; i < IO_WORDS; i++) begin
				if (w[i] !== g[i]) begin
					errors++;
					$display("%0t: out_word_%0d expected %08h actual %08h",
						$time, i, w[i], g[i]);
				end
			end
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	word_t                cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	in_item_t             req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	out_item_t            rsp;

	block_scoreboard sb = new();

	xxtea_nine_word_cipher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Result side: check each transfer, stall on a pattern that changes now and then.
	int  stall_mode = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  burst_stall = 1'b0;

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_block(rsp);
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 1500);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (hold_left == 0) begin
					hold_left = $urandom_range(1, 30);
					burst_stall = ~burst_stall;
				end else begin
					hold_left--;
				end
				rsp_stall <= burst_stall;
			end
		endcase
	end

	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t rand_block();
		blk_t b;
		for (int i = 0; i < IO_WORDS; i++)
			b[i] = rand_word();
		return in_item_t'({1'($urandom_range(0, 1)), b});
	endfunction

	function automatic in_item_t make_block(bit m, word_t w);
		blk_t b;
		for (int i = 0; i < IO_WORDS; i++)
			b[i] = w;
		return in_item_t'({m, b});
	endfunction

	task automatic send_block(in_item_t it);
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_block(it);
	endtask

	task automatic idle_sender(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold off until every pending block has come back.
	task automatic drain();
		idle_sender(1);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_setting(input word_t regs[8], input bit stray);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_KEY_0 + CFG_IDX_W'(i);
			cfg_data <= regs[i];
			@(posedge clk);
			sb.write_reg(REG_KEY_0 + CFG_IDX_W'(i), regs[i]);
		end
		if (stray) begin
			cfg_index <= REG_DELTA_3 + CFG_IDX_W'($urandom_range(1, 8));
			cfg_data <= $urandom;
			@(posedge clk);
			sb.write_reg(cfg_index, cfg_data);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_items(int count);
		int sent;
		int burst;
		in_item_t it;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < count; b++) begin
				it = rand_block();
				if ($urandom_range(0, 3) == 0) begin
					// encrypt, then decrypt the ciphertext right behind it
					it.mode = 1'b0;
					send_block(it);
					send_block(in_item_t'({1'b1, sb.cipher_block(it)}));
					sent += 2;
				end else begin
					send_block(it);
					sent++;
				end
			end
			case ($urandom_range(0, 19))
				0: drain();
				1, 2: idle_sender($urandom_range(20, 250));
				3, 4, 5, 6, 7: ;
				default: idle_sender($urandom_range(1, 12));
			endcase
		end
	endtask

	initial begin
		word_t regs[8];
		in_item_t it;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: zero key, zero deltas
		send_block(make_block(1'b0, '0));
		send_block(make_block(1'b1, '0));
		send_block(make_block(1'b0, '1));
		send_block(make_block(1'b1, '1));
		drain();

		foreach (regs[i]) regs[i] = '1;
		load_setting(regs, 1'b1);
		send_block(make_block(1'b0, '0));
		send_block(make_block(1'b1, '0));
		send_block(make_block(1'b0, '1));
		send_block(make_block(1'b1, '1));
		send_block(make_block(1'b0, 32'haaaa_aaaa));
		send_block(make_block(1'b1, 32'h5555_5555));
		send_block(make_block(1'b0, 32'h0000_0001));
		send_block(make_block(1'b1, 32'h0000_0001));
		send_block(make_block(1'b0, 32'h8000_0000));
		send_block(make_block(1'b1, 32'h8000_0000));
		drain();

		for (int i = 0; i < 4; i++) regs[i] = $urandom;
		for (int i = 4; i < 8; i++) regs[i] = 32'h9e37_79b9;
		load_setting(regs, 1'b0);
		for (int k = 0; k < 2; k++) begin
			it = rand_block();
			it.mode = 1'b0;
			send_block(it);
			send_block(in_item_t'({1'b1, sb.cipher_block(it)}));
		end
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			for (int i = 0; i < 8; i++) begin
				case ($urandom_range(0, 5))
					0: regs[i] = '0;
					1: regs[i] = '1;
					default: regs[i] = $urandom;
				endcase
			end
			if (ph == 0)
				foreach (regs[i]) regs[i] = '0;
			if (ph == 1)
				foreach (regs[i]) regs[i] = '1;
			if (ph == 5)
				for (int i = 4; i < 8; i++) regs[i] = '0;
			load_setting(regs, 1'($urandom_range(0, 1)));
			run_items(128);
			drain();
		end

		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
